[hw/rtl/dsu_pkg.sv]
// Shared types, constants and helper functions for the dual soft UART.
package dsu_pkg;

    // Ring geometry: each channel owns RING_DEPTH slots of one shared store.
    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int RAM_DEPTH  = 2 * RING_DEPTH;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);

    // Width of the bit timer countdown.
    localparam int TICK_W = 16;

    // Configuration register width, APB data and address widths.
    localparam int CFG_W    = 16;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    // Depth of the request queue between front and engine.
    localparam int Q_DEPTH  = 2;
    localparam int Q_PW     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    // Data bits per character.
    localparam logic [3:0] DATA_BITS = 4'd8;

    // Register indexes, selected by paddr[2].
    localparam logic REG_BIT_PERIOD   = 1'b0;
    localparam logic REG_FIRST_SAMPLE = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] BIT_PERIOD_RST   = 16'd16;
    localparam logic [CFG_W-1:0] FIRST_SAMPLE_RST = 16'd24;

    // Action codes on the request channel.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SEND = 2'd1;
    localparam logic [1:0] ACT_POP  = 2'd2;

    // Classified operation carried through the queue.
    typedef enum logic [1:0] {
        OP_TICK,
        OP_SEND,
        OP_POP,
        OP_NOP
    } op_t;

    // Bit engine mode.
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_TX,
        MODE_TX_STOP,
        MODE_RX
    } mode_t;

    // One queued request.
    typedef struct packed {
        op_t        op;
        logic       channel;
        logic [7:0] tx_byte;
        logic       rx_a;
        logic       rx_b;
    } item_t;

    // Result fields apart from the popped byte.
    typedef struct packed {
        logic tx_a;
        logic tx_b;
        logic accepted;
        logic pop_ok;
        logic busy;
        logic ovr_a;
        logic ovr_b;
    } res_t;

    // Advance a ring index with wrap-around.
    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
        ring_next = (idx == RING_AW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Store address of a ring slot for a channel.
    function automatic logic [RAM_AW-1:0] ring_addr(input logic ch,
                                                    input logic [RING_AW-1:0] idx);
        ring_addr = ch ? (RAM_AW'(RING_DEPTH) + RAM_AW'(idx)) : RAM_AW'(idx);
    endfunction

endpackage

[hw/rtl/dsu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dsu_front.sv]
// Request front end: accepts requests, classifies the action and queues them.
module dsu_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     action,
    input  logic           channel,
    input  logic [7:0]     tx_byte,
    input  logic           rx_line_a,
    input  logic           rx_line_b,
    output logic           q_valid,
    output dsu_pkg::item_t q_item,
    input  logic           q_take
);
    import dsu_pkg::*;

    item_t           slot_reg [Q_DEPTH];
    logic [Q_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    item_t           item_in;
    logic            push;
    logic            pop;

    // Classify the incoming action.
    always_comb
    begin
        item_in.channel = channel;
        item_in.tx_byte = tx_byte;
        item_in.rx_a    = rx_line_a;
        item_in.rx_b    = rx_line_b;
        case (action)
            ACT_TICK: item_in.op = OP_TICK;
            ACT_SEND: item_in.op = OP_SEND;
            ACT_POP:  item_in.op = OP_POP;
            default:  item_in.op = OP_NOP;
        endcase
    end

    // Queue control.
    assign in_stall = (count_reg == Q_CW'(Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_take && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    // The fill level never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("request queue overfilled");

    // A full queue that is drained and not refilled drops by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && q_take) |=> (count_reg == Q_CW'(Q_DEPTH - 1)))
        else $error("request queue count slipped while draining");

endmodule

[hw/rtl/dsu_engine.sv]
// Shared half-duplex bit engine, receive rings and result pipeline.
module dsu_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dsu_pkg::TICK_W-1:0] bit_period,
    input  logic [dsu_pkg::TICK_W-1:0] first_sample,
    input  logic                      q_valid,
    input  dsu_pkg::item_t            q_item,
    output logic                      q_take,
    output logic                      out_valid,
    input  logic                      out_stall,
    output dsu_pkg::res_t             out_res,
    output logic [7:0]                out_data
);
    import dsu_pkg::*;

    mode_t              mode_reg, mode_next;
    logic               chan_reg, chan_next;
    logic [7:0]         shift_reg, shift_next;
    logic [3:0]         bitcnt_reg, bitcnt_next;
    logic [TICK_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]         line_reg, line_next;
    logic [RING_AW-1:0] head_reg [2];
    logic [RING_AW-1:0] tail_reg [2];
    logic [RING_AW-1:0] head_next, tail_next;
    logic [RING_AW-1:0] head_adv, tail_adv;
    logic [1:0]         ovr_reg, ovr_next;
    logic               sel_ch;
    logic               accepted;
    logic               pop_ok;

    logic               ram_we, ram_re;
    logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]         ram_rdata;

    logic               s1_valid_reg;
    res_t               s1_res_reg, res_now;
    logic               s1_adv;
    logic               out_valid_reg;
    res_t               out_res_reg;
    logic [7:0]         out_data_reg;

    // Pipeline flow: the engine takes a request when the first result stage can move.
    assign s1_adv = !out_valid_reg || !out_stall;
    assign q_take = q_valid && (!s1_valid_reg || s1_adv);

    // Ring pointers of the channel in question: the active one on a tick.
    assign sel_ch   = (q_item.op == OP_TICK) ? chan_reg : q_item.channel;
    assign head_adv = ring_next(head_reg[sel_ch]);
    assign tail_adv = ring_next(tail_reg[sel_ch]);

    // Engine next state and ring updates for the request being executed.
    always_comb
    begin
        mode_next   = mode_reg;
        chan_next   = chan_reg;
        shift_next  = shift_reg;
        bitcnt_next = bitcnt_reg;
        cnt_next    = cnt_reg;
        line_next   = line_reg;
        head_next   = head_reg[sel_ch];
        tail_next   = tail_reg[sel_ch];
        ovr_next    = ovr_reg;
        accepted    = 1'b0;
        pop_ok      = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = ring_addr(sel_ch, head_adv);
        ram_raddr   = ring_addr(sel_ch, tail_adv);
        if (q_take)
        begin
            case (q_item.op)
                OP_TICK:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        // A low receive line starts reception, line a first.
                        if (!q_item.rx_a || !q_item.rx_b)
                        begin
                            mode_next   = MODE_RX;
                            chan_next   = q_item.rx_a;
                            bitcnt_next = '0;
                            cnt_next    = first_sample;
                        end
                    end
                    else if (cnt_reg <= TICK_W'(1))
                    begin
                        // Bit period boundary.
                        cnt_next = bit_period;
                        case (mode_reg)
                            MODE_TX:
                            begin
                                if (bitcnt_reg < DATA_BITS)
                                begin
                                    line_next[chan_reg] = shift_reg[0];
                                    shift_next          = {1'b0, shift_reg[7:1]};
                                    bitcnt_next         = bitcnt_reg + 1'b1;
                                end
                                else
                                begin
                                    line_next[chan_reg] = 1'b1;
                                    mode_next           = MODE_TX_STOP;
                                end
                            end
                            MODE_TX_STOP:
                            begin
                                mode_next = MODE_IDLE;
                            end
                            MODE_RX:
                            begin
                                if (bitcnt_reg < DATA_BITS)
                                begin
                                    bitcnt_next = bitcnt_reg + 1'b1;
                                    shift_next  = {chan_reg ? q_item.rx_b : q_item.rx_a,
                                                   shift_reg[7:1]};
                                end
                                else
                                begin
                                    // Store the byte unless the ring is full.
                                    if (head_adv == tail_reg[sel_ch])
                                    begin
                                        ovr_next[chan_reg] = 1'b1;
                                    end
                                    else
                                    begin
                                        head_next = head_adv;
                                        ram_we    = 1'b1;
                                    end
                                    mode_next = MODE_IDLE;
                                end
                            end
                            default:
                            begin
                                mode_next = MODE_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                OP_SEND:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        mode_next                 = MODE_TX;
                        chan_next                 = q_item.channel;
                        shift_next                = q_item.tx_byte;
                        bitcnt_next               = '0;
                        cnt_next                  = bit_period;
                        line_next[q_item.channel] = 1'b0;
                        accepted                  = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (head_reg[sel_ch] != tail_reg[sel_ch])
                    begin
                        tail_next = tail_adv;
                        ram_re    = 1'b1;
                        accepted  = 1'b1;
                        pop_ok    = 1'b1;
                    end
                end
                default:
                begin
                    accepted = 1'b0;
                end
            endcase
        end
    end

    // Result fields seen after the request.
    always_comb
    begin
        res_now.tx_a     = line_next[0];
        res_now.tx_b     = line_next[1];
        res_now.accepted = accepted;
        res_now.pop_ok   = pop_ok;
        res_now.busy     = (mode_next != MODE_IDLE);
        res_now.ovr_a    = ovr_next[0];
        res_now.ovr_b    = ovr_next[1];
    end

    // Engine state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            chan_reg    <= 1'b0;
            shift_reg   <= '0;
            bitcnt_reg  <= '0;
            cnt_reg     <= '0;
            line_reg    <= 2'b11;
            head_reg[0] <= '0;
            head_reg[1] <= '0;
            tail_reg[0] <= '0;
            tail_reg[1] <= '0;
            ovr_reg     <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            chan_reg         <= chan_next;
            shift_reg        <= shift_next;
            bitcnt_reg       <= bitcnt_next;
            cnt_reg          <= cnt_next;
            line_reg         <= line_next;
            head_reg[sel_ch] <= head_next;
            tail_reg[sel_ch] <= tail_next;
            ovr_reg          <= ovr_next;
        end
    end

    // Shared ring store for both channels.
    dsu_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (shift_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // First result stage: waits for the ring read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || s1_adv)
        begin
            s1_valid_reg <= q_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            s1_res_reg <= res_now;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_res_reg  <= s1_res_reg;
            out_data_reg <= s1_res_reg.pop_ok ? ram_rdata : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_data  = out_data_reg;

    // Outside a transmit both lines rest high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_TX) |-> (line_reg == 2'b11))
        else $error("transmit line low outside a transmit");

    // The bit counter never runs past the data bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        bitcnt_reg <= DATA_BITS)
        else $error("bit counter overran");

    // Only a send or a pop can be accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_take && accepted) |-> (q_item.op == OP_SEND || q_item.op == OP_POP))
        else $error("accepted flag on a tick or unused action");

    // A result waiting in the first stage is not lost while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("pending result dropped under stall");

endmodule

[hw/rtl/dual_soft_uart_half_duplex.sv]
// A request accepted into the queue is executed by the engine, registered in the first result stage,
// then in the output register, from which it can be taken on the output channel.
// Throughput: one request per cycle while the output does not stall; the engine executes each request
// as it is taken, and the two-entry request queue plus two result stages keep both sides moving.
// Reset (rst_n, async, active low): engine idle, both transmit lines high, rings empty,
// overrun flags clear, bit period 16 and first sample 24 ticks; ring contents undefined.
// Top level: configuration registers and the front, engine and queue wiring.
module dual_soft_uart_half_duplex (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dsu_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsu_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsu_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic                         channel,
    input  logic [7:0]                   tx_byte,
    input  logic                         rx_line_a,
    input  logic                         rx_line_b,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         tx_line_a,
    output logic                         tx_line_b,
    output logic                         accepted,
    output logic [7:0]                   read_data,
    output logic                         engine_busy,
    output logic                         overrun_a,
    output logic                         overrun_b
);
    import dsu_pkg::*;

    logic [CFG_W-1:0] bit_period_reg;
    logic [CFG_W-1:0] first_sample_reg;
    logic             cfg_write;
    logic             q_valid;
    logic             q_take;
    item_t            q_item;
    res_t             out_res;

    // Configuration port: always ready, register chosen by paddr[2].
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg   <= BIT_PERIOD_RST;
            first_sample_reg <= FIRST_SAMPLE_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_FIRST_SAMPLE)
            begin
                first_sample_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                bit_period_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            REG_BIT_PERIOD:   prdata = PDATA_W'(bit_period_reg);
            REG_FIRST_SAMPLE: prdata = PDATA_W'(first_sample_reg);
            default:          prdata = '0;
        endcase
    end

    // Front end and request queue.
    dsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .channel   (channel),
        .tx_byte   (tx_byte),
        .rx_line_a (rx_line_a),
        .rx_line_b (rx_line_b),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_take    (q_take)
    );

    // Bit engine, rings and result pipeline.
    dsu_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .bit_period   (TICK_W'(bit_period_reg)),
        .first_sample (TICK_W'(first_sample_reg)),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_take       (q_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_res      (out_res),
        .out_data     (read_data)
    );

    assign tx_line_a   = out_res.tx_a;
    assign tx_line_b   = out_res.tx_b;
    assign accepted    = out_res.accepted;
    assign engine_busy = out_res.busy;
    assign overrun_a   = out_res.ovr_a;
    assign overrun_b   = out_res.ovr_b;

endmodule

[verif/dual_soft_uart_half_duplex_tb.sv]
// Self-checking testbench for the dual soft UART with one shared half-duplex bit engine.
`timescale 1ns / 100ps

module dual_soft_uart_half_duplex_tb;
    import dsu_pkg::*;

    // The action field has one code that the block does not use.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One request as it stands on the input channel.
    typedef struct packed {
        logic [1:0] act;
        logic       chan;
        logic [7:0] data;
        logic       line_a;
        logic       line_b;
    } request_t;

    // One expected status word on the result channel.
    typedef struct packed {
        logic       tx_a;
        logic       tx_b;
        logic       acc;
        logic [7:0] rdata;
        logic       busy;
        logic       ovr_a;
        logic       ovr_b;
    } status_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          action = ACT_TICK;
    logic                channel = 1'b0;
    logic [7:0]          tx_byte = 8'h00;
    logic                rx_line_a = 1'b1;
    logic                rx_line_b = 1'b1;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                tx_line_a;
    logic                tx_line_b;
    logic                accepted;
    logic [7:0]          read_data;
    logic                engine_busy;
    logic                overrun_a;
    logic                overrun_b;

    dual_soft_uart_half_duplex uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .channel     (channel),
        .tx_byte     (tx_byte),
        .rx_line_a   (rx_line_a),
        .rx_line_b   (rx_line_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_line_a   (tx_line_a),
        .tx_line_b   (tx_line_b),
        .accepted    (accepted),
        .read_data   (read_data),
        .engine_busy (engine_busy),
        .overrun_a   (overrun_a),
        .overrun_b   (overrun_b)
    );

    // Requests waiting to be driven and status words waiting to be returned.
    request_t pending_req_q[$];
    status_t  expected_status_q[$];

    int err_count  = 0;
    int n_queued   = 0;
    int n_results  = 0;
    int n_settings = 0;
    int idle_pct   = 34;
    logic req_taken = 1'b0;

    // Predicted state of the block, starting from its reset values.
    logic [CFG_W-1:0]   cfg_period = BIT_PERIOD_RST;
    logic [CFG_W-1:0]   cfg_first  = FIRST_SAMPLE_RST;
    mode_t              m_mode     = MODE_IDLE;
    logic               m_chan     = 1'b0;
    logic [7:0]         m_shift    = 8'h00;
    logic [3:0]         m_bits     = 4'd0;
    logic [TICK_W-1:0]  m_count    = '0;
    logic [1:0]         m_lines    = 2'b11;
    logic [7:0]         ring_mem [0:RAM_DEPTH-1];
    logic [RING_AW-1:0] ring_head [0:1] = '{'0, '0};
    logic [RING_AW-1:0] ring_tail [0:1] = '{'0, '0};
    logic [1:0]         m_ovr      = 2'b00;

    // Clock.
    initial begin
        forever #10 clk = ~clk;
    end

    // Advance a ring index by one slot with wrap-around.
    function automatic logic [RING_AW-1:0] slot_after(input logic [RING_AW-1:0] idx);
        return (int'(idx) == RING_DEPTH - 1) ? '0 : idx + 1'b1;
    endfunction

    // Work out the status word that one request leaves behind, updating the predicted state.
    task automatic predict_uart_step(input request_t r, output status_t s);
        logic [RING_AW-1:0] nxt;
        logic               lvl;
        logic               acc;
        logic [7:0]         rd;
        acc = 1'b0;
        rd  = 8'h00;
        case (r.act)
            ACT_TICK: begin
                if (m_mode == MODE_IDLE) begin
                    // A low line in idle starts reception; line a has priority.
                    if (!r.line_a || !r.line_b) begin
                        m_mode  = MODE_RX;
                        m_chan  = r.line_a ? 1'b1 : 1'b0;
                        m_bits  = 4'd0;
                        m_count = cfg_first;
                    end
                end else if (m_count <= 1) begin
                    m_count = cfg_period;
                    case (m_mode)
                        MODE_TX: begin
                            if (m_bits < DATA_BITS) begin
                                m_lines[m_chan] = m_shift[0];
                                m_shift = m_shift >> 1;
                                m_bits  = m_bits + 1'b1;
                            end else begin
                                m_lines[m_chan] = 1'b1;
                                m_mode = MODE_TX_STOP;
                            end
                        end
                        MODE_TX_STOP: m_mode = MODE_IDLE;
                        MODE_RX: begin
                            if (m_bits < DATA_BITS) begin
                                lvl     = m_chan ? r.line_b : r.line_a;
                                m_bits  = m_bits + 1'b1;
                                m_shift = {lvl, m_shift[7:1]};
                            end else begin
                                // Store the byte unless the ring is full.
                                nxt = slot_after(ring_head[m_chan]);
                                if (nxt == ring_tail[m_chan]) begin
                                    m_ovr[m_chan] = 1'b1;
                                end else begin
                                    ring_head[m_chan] = nxt;
                                    ring_mem[int'(m_chan) * RING_DEPTH + int'(nxt)] = m_shift;
                                end
                                m_mode = MODE_IDLE;
                            end
                        end
                        default: m_mode = MODE_IDLE;
                    endcase
                end else begin
                    m_count = m_count - 1'b1;
                end
            end
            ACT_SEND: begin
                if (m_mode == MODE_IDLE) begin
                    m_mode  = MODE_TX;
                    m_chan  = r.chan;
                    m_shift = r.data;
                    m_bits  = 4'd0;
                    m_count = cfg_period;
                    m_lines[r.chan] = 1'b0;
                    acc = 1'b1;
                end
            end
            ACT_POP: begin
                if (ring_head[r.chan] != ring_tail[r.chan]) begin
                    nxt = slot_after(ring_tail[r.chan]);
                    ring_tail[r.chan] = nxt;
                    rd  = ring_mem[int'(r.chan) * RING_DEPTH + int'(nxt)];
                    acc = 1'b1;
                end
            end
            default: ;
        endcase
        s.tx_a  = m_lines[0];
        s.tx_b  = m_lines[1];
        s.acc   = acc;
        s.rdata = rd;
        s.busy  = (m_mode != MODE_IDLE);
        s.ovr_a = m_ovr[0];
        s.ovr_b = m_ovr[1];
    endtask

    // Print one mismatch and count it.
    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("MISMATCH at %0t, result %0d, %s: got %0h expected %0h",
                 $realtime, n_results, what, got, want);
        err_count++;
    endtask

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    task automatic add_req(input logic [1:0] act, input logic ch, input logic [7:0] data,
                           input logic la, input logic lb);
        pending_req_q.push_back('{act, ch, data, la, lb});
        n_queued++;
    endtask

    // A well-formed receive frame on one line, timed from the current register values,
    // with an occasional glitch on the active line.
    task automatic queue_rx_frame(input logic ch, input logic [7:0] data,
                                  input logic other_low);
        int   span;
        int   idx;
        logic lvl;
        span = int'(cfg_first) + 8 * int'(cfg_period);
        if (ch)
            add_req(ACT_TICK, rand_bit(), rand_byte(), 1'b1, 1'b0);
        else
            add_req(ACT_TICK, rand_bit(), rand_byte(), 1'b0, ~other_low);
        for (int k = 1; k <= span; k++) begin
            if (k < int'(cfg_first)) begin
                lvl = 1'b0;
            end else begin
                idx = (k - int'(cfg_first)) / int'(cfg_period);
                lvl = (idx > 7) ? 1'b1 : data[idx];
            end
            if ($urandom_range(29) == 0)
                lvl = ~lvl;
            if (ch)
                add_req(ACT_TICK, rand_bit(), rand_byte(), rand_bit(), lvl);
            else
                add_req(ACT_TICK, rand_bit(), rand_byte(), lvl, rand_bit());
        end
    endtask

    // A send followed by enough baud ticks to finish the frame and the hold period.
    task automatic queue_tx_frame(input logic ch, input logic [7:0] data);
        add_req(ACT_SEND, ch, data, rand_bit(), rand_bit());
        for (int k = 0; k < 10 * int'(cfg_period); k++)
            add_req(ACT_TICK, rand_bit(), rand_byte(),
                    $urandom_range(7) != 0, $urandom_range(7) != 0);
    endtask

    // Mostly complete frames with random content, the rest single requests and noise.
    task automatic queue_random_mix(input int budget);
        int stop_at;
        int pick;
        stop_at = n_queued + budget;
        while (n_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40)
                queue_rx_frame(rand_bit(), rand_byte(), rand_bit());
            else if (pick < 65)
                queue_tx_frame(rand_bit(), rand_byte());
            else if (pick < 78)
                add_req(ACT_POP, rand_bit(), rand_byte(), rand_bit(), rand_bit());
            else if (pick < 85)
                add_req(ACT_SEND, rand_bit(), rand_byte(), rand_bit(), rand_bit());
            else if (pick < 92)
                add_req(ACT_TICK, rand_bit(), rand_byte(), rand_bit(), rand_bit());
            else
                add_req(ACT_UNUSED, rand_bit(), rand_byte(), rand_bit(), rand_bit());
        end
    endtask

    // Wait until every request has gone in and every status word has come back.
    task automatic settle(input int max_cycles);
        int n;
        n = 0;
        while ((pending_req_q.size() != 0 || in_valid || expected_status_q.size() != 0)
               && n < max_cycles) begin
            @(negedge clk);
            n++;
        end
        repeat (8) @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic reg_sel, input logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {{(PDATA_W - CFG_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_sel == REG_BIT_PERIOD)
            cfg_period = value;
        else
            cfg_first = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_timing(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] first);
        apb_write(REG_BIT_PERIOD, period);
        apb_write(REG_FIRST_SAMPLE, first);
        n_settings++;
    endtask

    // Request driver: holds the payload while stalled, idles at random between requests.
    always @(negedge clk) begin : drive_requests
        request_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || req_taken) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_req_q.pop_front();
                action    <= nxt.act;
                channel   <= nxt.chan;
                tx_byte   <= nxt.data;
                rx_line_a <= nxt.line_a;
                rx_line_b <= nxt.line_b;
                in_valid  <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side stalls at random.
    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < idle_pct);
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge clk) begin : watch_channels
        request_t seen;
        status_t  st;
        status_t  want;
        if (!rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                seen = '{action, channel, tx_byte, rx_line_a, rx_line_b};
                predict_uart_step(seen, st);
                expected_status_q.push_back(st);
            end
            if (out_valid && !out_stall) begin
                if (expected_status_q.size() == 0) begin
                    flag_mismatch("result with no request outstanding", 8'h00, 8'h00);
                end else begin
                    want = expected_status_q.pop_front();
                    if (tx_line_a !== want.tx_a)
                        flag_mismatch("tx_line_a", tx_line_a, want.tx_a);
                    if (tx_line_b !== want.tx_b)
                        flag_mismatch("tx_line_b", tx_line_b, want.tx_b);
                    if (accepted !== want.acc)
                        flag_mismatch("accepted", accepted, want.acc);
                    if (read_data !== want.rdata)
                        flag_mismatch("read_data", read_data, want.rdata);
                    if (engine_busy !== want.busy)
                        flag_mismatch("engine_busy", engine_busy, want.busy);
                    if (overrun_a !== want.ovr_a)
                        flag_mismatch("overrun_a", overrun_a, want.ovr_a);
                    if (overrun_b !== want.ovr_b)
                        flag_mismatch("overrun_b", overrun_b, want.ovr_b);
                end
                n_results++;
            end
        end
    end

    // Stimulus sequence, phase by phase, with register writes only while nothing is in flight.
    initial begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Reset timing: pops from empty rings and the unused action code.
        n_settings = 1;
        add_req(ACT_POP, 1'b0, 8'h00, 1'b1, 1'b1);
        add_req(ACT_POP, 1'b1, 8'hFF, 1'b1, 1'b1);
        add_req(ACT_UNUSED, 1'b1, 8'hFF, 1'b0, 1'b0);
        settle(20000);

        // Shortest timing: a send with a refused send inside, a receive started with
        // both lines low, then a pop that succeeds and one that finds the ring empty.
        load_timing(16'd1, 16'd1);
        add_req(ACT_SEND, 1'b1, 8'h00, 1'b1, 1'b1);
        add_req(ACT_SEND, 1'b0, 8'hFF, 1'b1, 1'b1);
        for (int k = 0; k < 10; k++)
            add_req(ACT_TICK, 1'b0, 8'h00, 1'b1, 1'b1);
        queue_rx_frame(1'b0, 8'hFF, 1'b1);
        add_req(ACT_POP, 1'b0, 8'h00, 1'b1, 1'b1);
        add_req(ACT_POP, 1'b0, 8'h00, 1'b1, 1'b1);
        settle(20000);

        // Random traffic under several timings, one of them with no idling at all.
        load_timing(16'd2, 16'd3);
        queue_random_mix(10);
        settle(20000);
        idle_pct = 0;
        load_timing(16'd3, 16'd1);
        queue_random_mix(30);
        settle(20000);
        idle_pct = 34;
        load_timing(16'd1, 16'd4);
        queue_random_mix(10);
        settle(20000);

        // Fill both rings past capacity without popping, then drain them.
        load_timing(16'd1, 16'd1);
        for (int k = 0; k < RING_DEPTH; k++) begin
            queue_rx_frame(1'b0, rand_byte(), rand_bit());
            queue_rx_frame(1'b1, rand_byte(), 1'b0);
        end
        for (int k = 0; k < RING_DEPTH; k++) begin
            add_req(ACT_POP, 1'b0, rand_byte(), rand_bit(), rand_bit());
            add_req(ACT_POP, 1'b1, rand_byte(), rand_bit(), rand_bit());
        end
        settle(20000);

        // Longest timing last, since a frame at this rate cannot finish in the run.
        load_timing(16'hFFFF, 16'hFFFF);
        add_req(ACT_SEND, 1'b0, rand_byte(), 1'b1, 1'b1);
        for (int k = 0; k < 6; k++)
            add_req(ACT_TICK, rand_bit(), rand_byte(), rand_bit(), rand_bit());
        add_req(ACT_SEND, 1'b1, rand_byte(), 1'b1, 1'b1);
        add_req(ACT_POP, 1'b0, rand_byte(), 1'b1, 1'b1);
        add_req(ACT_POP, 1'b1, rand_byte(), 1'b1, 1'b1);
        add_req(ACT_UNUSED, rand_bit(), rand_byte(), 1'b0, 1'b0);
        settle(20000);

        if (expected_status_q.size() != 0)
            flag_mismatch("results never returned", 8'(expected_status_q.size()), 8'h00);

        $display("Checked %0d results from %0d requests over %0d register settings.",
                 n_results, n_queued, n_settings);
        $display("Covered sends, receives, refused sends and pops, ring overrun on both lines,");
        $display("and bit periods from 1 to 65535 ticks.");
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dsu_pkg.sv
hw/rtl/dsu_ram.sv
hw/rtl/dsu_front.sv
hw/rtl/dsu_engine.sv
hw/rtl/dual_soft_uart_half_duplex.sv
verif/dual_soft_uart_half_duplex_tb.sv
